FILE: hdl/urlpd_pkg.sv
// ----------------------------------------------------------------------------
// urlpd_pkg
// Types, character constants and decode helpers for the URL path decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

	// path length limit and the saturation point of the 16-bit counter
	localparam logic [31:0] MAX_PATH_LEN = 32'd65535;
	localparam logic [15:0] PATH_CAP     = (MAX_PATH_LEN < 32'd65535) ?
		MAX_PATH_LEN[15:0] : 16'hFFFF;

	// results one input byte can cause, end record included
	localparam int MAX_RES = 4;
	localparam int RES_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_HEX   = 2'd1;
	localparam logic [1:0] ST_DOT_SLASH = 2'd2;
	localparam logic [1:0] ST_TRUNC     = 2'd3;

	typedef enum logic [4:0] {
		PH_NORMAL = 5'b00001,
		PH_PCT1   = 5'b00010,
		PH_PCT2   = 5'b00100,
		PH_QUERY  = 5'b01000,
		PH_ERROR  = 5'b10000
	} phase_t;

	// per-uri state plus the result list built for one byte
	typedef struct packed {
		phase_t                   phase;
		logic [7:0]               first_digit;
		logic                     held_slash;
		logic                     prev_slash;
		logic [1:0]               err;
		logic [15:0]              path_count;
		logic [RES_W-1:0]         n;
		logic [MAX_RES-1:0][7:0]  bytes;
		logic [MAX_RES-1:0]       qry;
	} dec_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	// letters have low nibble 1..6, nine below their value
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	function automatic dec_t emit_path(input dec_t d, input logic [7:0] b);
		dec_t r;
		r = d;
		if (r.n < RES_W'(MAX_RES)) begin
			r.bytes[r.n[IDX_W-1:0]] = b;
			r.qry[r.n[IDX_W-1:0]]   = 1'b0;
			r.n                     = r.n + RES_W'(1);
		end
		if (r.path_count < PATH_CAP)
			r.path_count = r.path_count + 16'd1;
		r.prev_slash = (b == CH_SLASH);
		return r;
	endfunction

	function automatic dec_t set_error(input dec_t d, input logic [1:0] code);
		dec_t r;
		r            = d;
		r.phase      = PH_ERROR;
		r.err        = code;
		r.held_slash = 1'b0;
		return r;
	endfunction

	function automatic dec_t process_char(input dec_t d, input logic [7:0] c,
		input logic lenient);
		dec_t r;
		r = d;
		if (lenient)
			r = emit_path(r, c);
		else if (c == CH_DOT && r.prev_slash)
			r = set_error(r, ST_DOT_SLASH);
		else if (c == CH_SLASH)
			r.held_slash = 1'b1;
		else
			r = emit_path(r, c);
		return r;
	endfunction

endpackage

FILE: hdl/url_path_percent_decoder_unit.sv
// ----------------------------------------------------------------------------
// url_path_percent_decoder_unit
// Percent decoder for URI paths with strict and lenient modes.
// ----------------------------------------------------------------------------
// the first result of a byte is offered in the cycle after its transfer
// throughput, limited only by the result register: one byte per cycle while
//   each byte gives at most one result and out_ready is high; a byte with k
//   results (k <= 4) holds it while all k drain, one record a cycle on out_ready
// reset: arst_n clears decode state, mode and result count/index/end asynchronously
module url_path_percent_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// mode register
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        in_query,
	output logic        is_end,
	output logic [1:0]  status,
	output logic [15:0] path_length,
	output logic        run_last
);
	import urlpd_pkg::*;

	// mode register, sampled on every byte
	logic lenient_q;

	// per-uri decode state
	phase_t      phase_q;
	logic [7:0]  first_digit_q;
	logic        held_slash_q;
	logic        prev_slash_q;
	logic [1:0]  err_q;
	logic [15:0] path_count_q;

	// result register: records of one byte, drained in order
	logic [MAX_RES-1:0][7:0] res_byte_q;
	logic [MAX_RES-1:0]      res_qry_q;
	logic [RES_W-1:0]        res_cnt_q;
	logic [IDX_W-1:0]        res_idx_q;
	logic                    res_end_q;
	logic [1:0]              res_status_q;
	logic [15:0]             res_len_q;

	dec_t             d;
	logic [RES_W-1:0] nxt_cnt;
	logic [1:0]       end_status;
	logic             in_xfer;
	logic             out_xfer;
	logic             at_last_rec;

	// ---------------------------------------------------------------- handshake
	assign at_last_rec = ({1'b0, res_idx_q} == res_cnt_q - RES_W'(1));
	assign out_valid   = (res_cnt_q != '0);
	assign out_xfer    = out_valid && out_ready;
	// free when empty, or when the final record leaves in this cycle
	assign in_ready    = !out_valid || (out_xfer && at_last_rec);
	assign in_xfer     = in_valid && in_ready;

	// ---------------------------------------------------------------- decode
	always_comb begin
		d.phase       = phase_q;
		d.first_digit = first_digit_q;
		d.held_slash  = held_slash_q;
		d.prev_slash  = prev_slash_q;
		d.err         = err_q;
		d.path_count  = path_count_q;
		d.n           = '0;
		d.bytes       = '0;
		d.qry         = '0;

		case (phase_q)
			PH_QUERY: begin
				// query bytes pass verbatim
				d.bytes[0] = in_byte;
				d.qry[0]   = 1'b1;
				d.n        = RES_W'(1);
			end
			PH_NORMAL: begin
				// a held slash is dropped only when strict and followed by '/'
				if (d.held_slash) begin
					d.held_slash = 1'b0;
					if (lenient_q || in_byte != CH_SLASH)
						d = emit_path(d, CH_SLASH);
				end
				if (in_byte == CH_PCT)
					d.phase = PH_PCT1;
				else if (in_byte == CH_QMARK)
					d.phase = PH_QUERY;
				else
					d = process_char(d, in_byte, lenient_q);
			end
			PH_PCT1: begin
				if (is_hex(in_byte)) begin
					d.first_digit = in_byte;
					d.phase       = PH_PCT2;
				end else if (!lenient_q) begin
					d = set_error(d, ST_BAD_HEX);
				end else begin
					// bad escape goes out literally, not reinterpreted
					d       = emit_path(d, CH_PCT);
					d       = emit_path(d, in_byte);
					d.phase = PH_NORMAL;
				end
			end
			PH_PCT2: begin
				if (is_hex(in_byte)) begin
					d.phase = PH_NORMAL;
					d = process_char(d, {hex_val(d.first_digit), hex_val(in_byte)},
						lenient_q);
				end else if (!lenient_q) begin
					d = set_error(d, ST_BAD_HEX);
				end else begin
					d       = emit_path(d, CH_PCT);
					d       = emit_path(d, d.first_digit);
					d       = emit_path(d, in_byte);
					d.phase = PH_NORMAL;
				end
			end
			PH_ERROR: begin
				// swallow everything until the last byte
			end
			default: begin
				d.phase = PH_ERROR;
			end
		endcase

		// end of uri: flush or, in strict mode, fail a pending escape; flush a held slash
		if (in_last && d.phase != PH_ERROR) begin
			if (d.phase == PH_PCT1 || d.phase == PH_PCT2) begin
				if (!lenient_q) begin
					d = set_error(d, ST_TRUNC);
				end else begin
					d = emit_path(d, CH_PCT);
					if (d.phase == PH_PCT2)
						d = emit_path(d, d.first_digit);
				end
			end
			if (d.phase != PH_ERROR && d.held_slash) begin
				d.held_slash = 1'b0;
				d = emit_path(d, CH_SLASH);
			end
		end

		end_status = (d.phase == PH_ERROR) ? d.err : ST_OK;
		// end record always lands after the byte records
		nxt_cnt    = d.n + RES_W'(in_last);
	end

	// ---------------------------------------------------------------- mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lenient_q <= 1'b0;
		end else if (cfg_we) begin
			lenient_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------- state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_NORMAL;
			first_digit_q <= '0;
			held_slash_q  <= 1'b0;
			prev_slash_q  <= 1'b0;
			err_q         <= ST_OK;
			path_count_q  <= '0;
		end else if (in_xfer) begin
			if (in_last) begin
				// last byte taken: back to a fresh uri, mode kept
				phase_q       <= PH_NORMAL;
				first_digit_q <= '0;
				held_slash_q  <= 1'b0;
				prev_slash_q  <= 1'b0;
				err_q         <= ST_OK;
				path_count_q  <= '0;
			end else begin
				phase_q       <= d.phase;
				first_digit_q <= d.first_digit;
				held_slash_q  <= d.held_slash;
				prev_slash_q  <= d.prev_slash;
				err_q         <= d.err;
				path_count_q  <= d.path_count;
			end
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
			res_idx_q <= '0;
			res_end_q <= 1'b0;
		end else if (in_xfer) begin
			res_cnt_q <= nxt_cnt;
			res_idx_q <= '0;
			res_end_q <= in_last;
		end else if (out_xfer) begin
			if (at_last_rec)
				res_cnt_q <= '0;
			else
				res_idx_q <= res_idx_q + IDX_W'(1);
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_byte_q   <= d.bytes;
			res_qry_q    <= d.qry;
			res_status_q <= end_status;
			res_len_q    <= d.path_count;
		end
	end

	// ---------------------------------------------------------------- output mux
	assign run_last    = at_last_rec;
	assign is_end      = res_end_q && at_last_rec;
	assign out_byte    = is_end ? 8'h00 : res_byte_q[res_idx_q];
	assign in_query    = is_end ? 1'b0 : res_qry_q[res_idx_q];
	assign status      = is_end ? res_status_q : ST_OK;
	assign path_length = is_end ? res_len_q : 16'h0000;

`ifndef SYNTHESIS
	// read pointer stays inside the filled records
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, res_idx_q} < res_cnt_q))
		else $error("result index beyond record count");

	// an end record closes the run of its byte
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_end) |-> run_last)
		else $error("end record not last of its run");

	// a last byte leaves a fresh uri behind
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_last) |=> (phase_q == PH_NORMAL && path_count_q == 16'h0000))
		else $error("uri state not cleared after last byte");

	// the path counter never passes its cap
	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		path_count_q <= PATH_CAP)
		else $error("path count above cap");
`endif

endmodule

FILE: tb/sv/url_path_percent_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_path_percent_decoder_unit_tb
// Self-checking bench for the uri path decoder: bytes go in over a
// valid/ready channel with random gaps, decoded records come back with random
// back-pressure. A scoreboard class predicts every record of every byte in
// both strict and lenient mode and checks them in order, field by field.
// ----------------------------------------------------------------------------
module url_path_percent_decoder_unit_tb;
	import urlpd_pkg::*;

	// one decoded record as it leaves the block
	typedef struct packed {
		logic [7:0]  data;
		logic        qry;
		logic        fin;
		logic [1:0]  st;
		logic [15:0] len;
		logic        tail;
	} rec_t;

	// ------------------------------------------------------------------------
	// scoreboard: decoder prediction plus the queue of records still owed
	// ------------------------------------------------------------------------
	class decode_scoreboard;
		bit          lenient;
		phase_t      ph;
		logic [7:0]  digit1;
		bit          slash_held;
		bit          last_out_slash;
		logic [1:0]  err_code;
		logic [15:0] plen;
		rec_t        step_recs[$];
		rec_t        expected_recs[$];
		int          errors;

		function new();
			lenient = 1'b0;
			errors  = 0;
			clear_uri();
		endfunction

		static function bit is_hex_digit(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
				(c >= "A" && c <= "F");
		endfunction

		// value of one hex digit, either case
		static function logic [3:0] nibble(logic [7:0] c);
			if (c <= "9")
				return 4'(c - "0");
			return 4'((c | 8'h20) - "a" + 8'd10);
		endfunction

		function void clear_uri();
			ph             = PH_NORMAL;
			digit1         = 8'h00;
			slash_held     = 1'b0;
			last_out_slash = 1'b0;
			err_code       = ST_OK;
			plen           = 16'd0;
		endfunction

		// at most four records leave for one byte
		function void add_rec(logic [7:0] b, bit q, bit e, logic [1:0] s,
			logic [15:0] n);
			rec_t r;
			if (step_recs.size() >= MAX_RES)
				return;
			r = '{data: b, qry: q, fin: e, st: s, len: n, tail: 1'b0};
			step_recs.push_back(r);
		endfunction

		function void put_path(logic [7:0] b);
			add_rec(b, 1'b0, 1'b0, ST_OK, 16'd0);
			if (plen < PATH_CAP)
				plen++;
			last_out_slash = (b == CH_SLASH);
		endfunction

		function void fail(logic [1:0] code);
			ph         = PH_ERROR;
			err_code   = code;
			slash_held = 1'b0;
		endfunction

		// slash and dot rules apply only in strict mode
		function void take_char(logic [7:0] c);
			if (lenient)
				put_path(c);
			else if (c == CH_DOT && last_out_slash)
				fail(ST_DOT_SLASH);
			else if (c == CH_SLASH)
				slash_held = 1'b1;
			else
				put_path(c);
		endfunction

		function void close_uri();
			if (ph != PH_ERROR) begin
				if (ph == PH_PCT1 || ph == PH_PCT2) begin
					if (!lenient) begin
						fail(ST_TRUNC);
					end else begin
						put_path(CH_PCT);
						if (ph == PH_PCT2)
							put_path(digit1);
					end
				end
				if (ph != PH_ERROR && slash_held) begin
					slash_held = 1'b0;
					put_path(CH_SLASH);
				end
			end
			add_rec(8'h00, 1'b0, 1'b1, (ph == PH_ERROR) ? err_code : ST_OK, plen);
			clear_uri();
		endfunction

		// one accepted input transfer
		function void note_byte(logic [7:0] b, bit l);
			step_recs.delete();
			case (ph)
				PH_QUERY: begin
					add_rec(b, 1'b1, 1'b0, ST_OK, 16'd0);
				end
				PH_NORMAL: begin
					if (slash_held) begin
						slash_held = 1'b0;
						if (lenient || b != CH_SLASH)
							put_path(CH_SLASH);
					end
					if (b == CH_PCT)
						ph = PH_PCT1;
					else if (b == CH_QMARK)
						ph = PH_QUERY;
					else
						take_char(b);
				end
				PH_PCT1: begin
					if (is_hex_digit(b)) begin
						digit1 = b;
						ph     = PH_PCT2;
					end else if (!lenient) begin
						fail(ST_BAD_HEX);
					end else begin
						put_path(CH_PCT);
						put_path(b);
						ph = PH_NORMAL;
					end
				end
				PH_PCT2: begin
					if (is_hex_digit(b)) begin
						ph = PH_NORMAL;
						take_char({nibble(digit1), nibble(b)});
					end else if (!lenient) begin
						fail(ST_BAD_HEX);
					end else begin
						put_path(CH_PCT);
						put_path(digit1);
						put_path(b);
						ph = PH_NORMAL;
					end
				end
				default: ;
			endcase
			if (l)
				close_uri();
			if (step_recs.size() > 0)
				step_recs[step_recs.size() - 1].tail = 1'b1;
			foreach (step_recs[i])
				expected_recs.push_back(step_recs[i]);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", what);
		endtask

		// one accepted output transfer against the oldest record owed
		task check_record(rec_t got);
			rec_t want;
			if (expected_recs.size() == 0) begin
				report($sformatf("record with nothing owed: byte %h end %b",
					got.data, got.fin));
				return;
			end
			want = expected_recs.pop_front();
			if (got.data !== want.data)
				report($sformatf("out_byte %h, want %h", got.data, want.data));
			if (got.qry !== want.qry)
				report($sformatf("in_query %b, want %b", got.qry, want.qry));
			if (got.fin !== want.fin)
				report($sformatf("is_end %b, want %b", got.fin, want.fin));
			if (got.st !== want.st)
				report($sformatf("status %0d, want %0d", got.st, want.st));
			if (got.len !== want.len)
				report($sformatf("path_length %0d, want %0d", got.len, want.len));
			if (got.tail !== want.tail)
				report($sformatf("run_last %b, want %b", got.tail, want.tail));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block inputs, all known from time zero
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte   = 8'h00;
	logic        in_last   = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        in_query;
	logic        is_end;
	logic [1:0]  status;
	logic [15:0] path_length;
	logic        run_last;

	// when set, neither side idles
	bit quiet = 1'b0;

	decode_scoreboard sb = new();

	// raw bytes of one generated uri, bit 8 marks the last byte
	logic [8:0] uri_bytes[$];

	always #2 clk = ~clk;

	url_path_percent_decoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.in_query    (in_query),
		.is_end      (is_end),
		.status      (status),
		.path_length (path_length),
		.run_last    (run_last)
	);

	// ------------------------------------------------------------------------
	// result side: check each output transfer, stall at random
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rec_t got;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = '{data: out_byte, qry: in_query, fin: is_end, st: status,
				len: path_length, tail: run_last};
			sb.check_record(got);
		end
		out_ready <= quiet || ($urandom_range(0, 99) >= 11);
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic bit idling();
		return !quiet && ($urandom_range(0, 99) < 11);
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit up);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return (up ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] random_nonhex();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (decode_scoreboard::is_hex_digit(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// any byte that neither opens an escape nor ends the path
	function automatic logic [7:0] random_plain();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == CH_PCT || c == CH_QMARK)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// one input transfer, with a random gap in front
	task automatic send_byte(input logic [7:0] b, input bit l);
		while (idling()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b, l);
	endtask

	task automatic send_str(input string s, input bit end_it);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], end_it && (i == s.len() - 1));
	endtask

	// hold the sender until every owed record is back, then let the block
	// finish any byte that gave no record
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_recs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mode write, only ever issued while the block is idle
	task automatic set_mode(input bit m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we     <= 1'b0;
		sb.lenient  = m;
	endtask

	// mostly well-formed uri with random content; cut leaves it unfinished
	task automatic build_uri(input bit cut);
		int         tokens;
		int         r;
		logic [7:0] v;
		uri_bytes.delete();
		tokens = $urandom_range(1, 10);
		for (int t = 0; t < tokens; t++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				uri_bytes.push_back({1'b0, random_plain()});
			end else if (r < 50) begin
				uri_bytes.push_back({1'b0, CH_SLASH});
			end else if (r < 60) begin
				uri_bytes.push_back({1'b0, CH_DOT});
			end else if (r < 80) begin
				// good escape, biased toward the characters with rules
				r = $urandom_range(0, 19);
				if (r < 5)
					v = CH_SLASH;
				else if (r < 8)
					v = CH_DOT;
				else if (r < 10)
					v = CH_QMARK;
				else if (r < 11)
					v = CH_PCT;
				else
					v = 8'($urandom_range(0, 255));
				uri_bytes.push_back({1'b0, CH_PCT});
				uri_bytes.push_back({1'b0, hex_digit(v[7:4], 1'($urandom_range(0, 1)))});
				uri_bytes.push_back({1'b0, hex_digit(v[3:0], 1'($urandom_range(0, 1)))});
			end else if (r < 85) begin
				// broken escape: bad first or bad second digit
				uri_bytes.push_back({1'b0, CH_PCT});
				if ($urandom_range(0, 1))
					uri_bytes.push_back({1'b0, hex_digit(4'($urandom_range(0, 15)), 1'b0)});
				uri_bytes.push_back({1'b0, random_nonhex()});
			end else if (r < 92) begin
				// query part, raw bytes of any value
				uri_bytes.push_back({1'b0, CH_QMARK});
				repeat ($urandom_range(0, 4))
					uri_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
			end else begin
				// lone percent, truncated if it ends the uri
				uri_bytes.push_back({1'b0, CH_PCT});
			end
		end
		uri_bytes[uri_bytes.size() - 1][8] = !cut;
	endtask

	task automatic send_uri();
		foreach (uri_bytes[i])
			send_byte(uri_bytes[i][7:0], uri_bytes[i][8]);
	endtask

	// one mode setting, about n_items bytes, noise mixed in
	task automatic run_phase(input bit mode, input int n_items);
		int sent;
		settle();
		set_mode(mode);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 15) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
				sent++;
			end else begin
				build_uri(1'b0);
				sent += uri_bytes.size();
				send_uri();
			end
		end
		// sometimes stop mid-uri so the next mode meets a half-decoded path
		if ($urandom_range(0, 1)) begin
			build_uri(1'b1);
			send_uri();
		end
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// strict mode out of reset, written once to be sure
		set_mode(1'b0);
		// leading dot has no slash before it
		send_str(".a", 1'b1);
		// doubled slash collapses
		send_str("//a", 1'b1);
		// escaped slash then a dot after it
		send_str("%2F.", 1'b1);
		// escaped question mark stays in the path; extremes of the byte range
		send_str("%3F", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_QMARK, 1'b0);
		send_byte(8'h00, 1'b1);
		// bad hex digit, following bytes swallowed
		send_str("%G%", 1'b1);
		// truncated escape at the end
		send_str("%4", 1'b1);
		// held slash flushed before the end record
		send_str("a/", 1'b1);
		// slash held across a switch to lenient
		send_str("b/", 1'b0);
		settle();
		set_mode(1'b1);
		send_str("/", 1'b1);
		// lenient: bad second digit gives the most records for one byte
		send_str("%4?", 1'b1);
		// lenient: bad first digit is literal, even a question mark
		send_str("%?", 1'b1);
		// lenient: truncated escape at the end comes out literally
		send_str("%a", 1'b1);

		// random part
		run_phase(1'b0, 50);
		run_phase(1'b1, 50);

		// path with no idling on either side
		settle();
		set_mode(1'b1);
		quiet = 1'b1;
		for (int i = 0; i < 32; i++)
			send_byte(random_plain(), i == 31);
		settle();
		quiet = 1'b0;

		run_phase(1'b0, 40);
		for (int k = 0; k < 6; k++)
			run_phase(1'($urandom_range(0, 1)), 12);

		// drain and let the block go quiet
		settle();
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
